>>> src/gbi_pkg.sv
// Shared types, codes and constants of the grid bilinear interpolator.
// Used by gbi_front, gbi_div, gbi_back and grid_bilinear_interpolator_core.
package gbi_pkg;

    localparam int K_POINTS_DEF   = 256;
    localparam int TAU_POINTS_DEF = 64;
    localparam int SOURCES_DEF    = 4;

    // depth of the command queue between front and back
    localparam int FQ_DEPTH = 2;

    // weight of 1.0, 16 fraction bits
    localparam logic [16:0] ONE_W = 17'd65536;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_K_COUNT   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TAU_COUNT = 2'd1;
    localparam logic [8:0] K_COUNT_RST   = 9'd256;
    localparam logic [6:0] TAU_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        OP_WR_K   = 2'd0,
        OP_WR_TAU = 2'd1,
        OP_WR_VAL = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        write_address;
        logic signed [31:0] write_value;
        logic signed [31:0] query_k;
        logic signed [31:0] query_log_tau;
        logic [1:0]         source;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [7:0]         k_bin;
        logic [5:0]         tau_bin;
        logic               k_clamped;
        logic               tau_clamped;
        logic               saturated;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_op                op;
        logic [15:0]        write_address;
        logic signed [31:0] write_value;
        logic signed [31:0] query_k;
        logic signed [31:0] query_log_tau;
        logic [1:0]         source;
    } t_cmd;

    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic signed [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [16:0] weight;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_RL, S_T_CL, S_T_C0, S_T_RD, S_T_CK, S_T_DIV,
        S_K_RL, S_K_CL, S_K_C0, S_K_RD, S_K_CK, S_K_DIV,
        S_IX0, S_IX1, S_IX2,
        S_V0, S_V1, S_V2, S_V3, S_V4,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_DONE
    } t_state;

endpackage

>>> src/gbi_front.sv
// Front part: accepts input items, classifies them and drops out-of-range writes.
// Holds a short command queue for gbi_back; depends on gbi_pkg.
module gbi_front #(
    parameter int K_POINTS   = gbi_pkg::K_POINTS_DEF,
    parameter int TAU_POINTS = gbi_pkg::TAU_POINTS_DEF,
    parameter int SOURCES    = gbi_pkg::SOURCES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  gbi_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output gbi_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    localparam int QAW = $clog2(gbi_pkg::FQ_DEPTH);
    localparam longint TBL_DEPTH = longint'(SOURCES) * K_POINTS * TAU_POINTS;

    gbi_pkg::t_cmd r_q [gbi_pkg::FQ_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    gbi_pkg::t_cmd cmd;
    logic          keep, do_push, do_pop;

    // classify the item and check the write address
    always_comb begin
        cmd.op            = gbi_pkg::t_op'(i_item.func);
        cmd.write_address = i_item.write_address;
        cmd.write_value   = i_item.write_value;
        cmd.query_k       = i_item.query_k;
        cmd.query_log_tau = i_item.query_log_tau;
        cmd.source        = i_item.source;
        unique case (cmd.op)
            gbi_pkg::OP_WR_K:   keep = 32'(i_item.write_address) < K_POINTS;
            gbi_pkg::OP_WR_TAU: keep = 32'(i_item.write_address) < TAU_POINTS;
            gbi_pkg::OP_WR_VAL: keep = 64'(i_item.write_address) < TBL_DEPTH;
            default:            keep = 1'b1;
        endcase
    end

    assign full        = r_cnt == (QAW+1)'(gbi_pkg::FQ_DEPTH);
    assign do_push     = push && !full && keep;
    assign do_pop      = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rp];

    // store the command at the tail
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= QAW'((32'(r_wp) + 1) % gbi_pkg::FQ_DEPTH);
            end
            if (do_pop) begin
                r_rp <= QAW'((32'(r_rp) + 1) % gbi_pkg::FQ_DEPTH);
            end
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end
endmodule

>>> src/gbi_div.sv
// Weight divider: (num << 16) / den, one quotient bit per cycle, with
// the zero and full-weight cases settled at start; depends on gbi_pkg.
module gbi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbi_pkg::t_div_req i_req,
    output gbi_pkg::t_div_rsp o_rsp
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem, r_den;
    logic [16:0] r_quo;
    logic [33:0] rem2;
    logic        ge;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    assign o_rsp.done   = r_done;
    assign o_rsp.weight = r_quo;

    // restoring division, special cases at start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den <= 0 || i_req.num <= 0) begin
                    r_quo  <= '0;
                    r_done <= 1'b1;
                end else if (i_req.num >= i_req.den) begin
                    r_quo  <= gbi_pkg::ONE_W;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_req.num;
                    r_den  <= i_req.den;
                    r_quo  <= '0;
                    r_cnt  <= 5'd16;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? 33'(rem2 - {1'b0, r_den}) : rem2[32:0];
                r_quo <= {r_quo[15:0], ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> src/gbi_back.sv
// Back part: grid and table memories, bin search sequencer, blend and result register.
// Depends on gbi_pkg and gbi_div.
module gbi_back #(
    parameter int K_POINTS   = gbi_pkg::K_POINTS_DEF,
    parameter int TAU_POINTS = gbi_pkg::TAU_POINTS_DEF,
    parameter int SOURCES    = gbi_pkg::SOURCES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  gbi_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    input  logic                       i_cfg_valid,
    input  logic [gbi_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [gbi_pkg::CFG_DW-1:0] i_cfg_data,
    output logic                       empty,
    input  logic                       pop,
    output gbi_pkg::t_out_item         o_result
);
    localparam int KBW       = $clog2(K_POINTS);
    localparam int TBW       = $clog2(TAU_POINTS);
    localparam int KCW       = $clog2(K_POINTS + 1);
    localparam int TCW       = $clog2(TAU_POINTS + 1);
    localparam int TBL_DEPTH = SOURCES * K_POINTS * TAU_POINTS;
    localparam int TAW       = $clog2(TBL_DEPTH);
    localparam int IW        = $clog2(K_POINTS * TAU_POINTS) + 3;
    localparam logic signed [36:0] MAXV = 37'sd2147483647;
    localparam logic signed [36:0] MINV = -37'sd2147483648;

    // memories
    logic signed [31:0] k_mem [K_POINTS];
    logic signed [31:0] t_mem [TAU_POINTS];
    logic signed [31:0] v_mem [TBL_DEPTH];
    logic signed [31:0] r_kq, r_tq, r_vq;
    logic               r_vok;

    gbi_pkg::t_state r_state, n_state;
    logic [8:0] r_k_count;
    logic [6:0] r_tau_count;
    logic [KCW-1:0] kc;
    logic [TCW-1:0] tc;

    logic signed [31:0] r_qk, r_qt, r_prev, r_last;
    logic [1:0]         r_src;
    logic [KCW-1:0]     r_i;
    logic [KBW-1:0]     r_kb;
    logic [TBW-1:0]     r_tb;
    logic [16:0]        r_uk, r_ut;
    logic               r_kcl, r_tcl;
    logic [IW-1:0]      r_m, r_base, r_row, r_idx;
    logic signed [31:0] r_v00, r_v01, r_v10, r_v11;
    logic signed [51:0] r_p;
    logic signed [33:0] r_lo, r_hi;
    logic signed [36:0] r_r;
    logic               r_out_valid;
    gbi_pkg::t_out_item r_out;

    logic [KBW-1:0]     k_addr;
    logic [TBW-1:0]     t_addr;
    logic [IW-1:0]      v_idx;
    logic signed [31:0] vval;
    logic signed [17:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [51:0] prod;
    logic signed [52:0] acc;
    logic signed [36:0] rnd;
    logic               k_match;
    logic [31:0]        wa32;
    gbi_pkg::t_div_req  div_req;
    gbi_pkg::t_div_rsp  div_rsp;

    gbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // effective counts
    always_comb begin
        if (r_k_count < 9'd2) begin
            kc = KCW'(2);
        end else if (32'(r_k_count) > K_POINTS) begin
            kc = KCW'(K_POINTS);
        end else begin
            kc = KCW'(r_k_count);
        end
        if (r_tau_count < 7'd2) begin
            tc = TCW'(2);
        end else if (32'(r_tau_count) > TAU_POINTS) begin
            tc = TCW'(TAU_POINTS);
        end else begin
            tc = TCW'(r_tau_count);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_count   <= gbi_pkg::K_COUNT_RST;
            r_tau_count <= gbi_pkg::TAU_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gbi_pkg::CFG_K_COUNT:   r_k_count   <= i_cfg_data[8:0];
                gbi_pkg::CFG_TAU_COUNT: r_tau_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // read addresses per state
    assign wa32 = 32'(i_cmd.write_address);
    always_comb begin
        k_addr = KBW'(r_i);
        t_addr = TBW'(r_i);
        v_idx  = r_idx;
        case (r_state)
            gbi_pkg::S_T_RL: t_addr = TBW'(tc - TCW'(1));
            gbi_pkg::S_T_CL: t_addr = '0;
            gbi_pkg::S_K_RL: k_addr = KBW'(kc - KCW'(1));
            gbi_pkg::S_K_CL: k_addr = '0;
            gbi_pkg::S_V1:   v_idx  = r_idx + IW'(1);
            gbi_pkg::S_V2:   v_idx  = r_idx + IW'(kc);
            gbi_pkg::S_V3:   v_idx  = r_idx + IW'(kc) + IW'(1);
            default: ;
        endcase
    end

    // write on accepted commands, registered reads
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == gbi_pkg::OP_WR_K) begin
            k_mem[wa32[KBW-1:0]] <= i_cmd.write_value;
        end
        r_kq <= k_mem[k_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == gbi_pkg::OP_WR_TAU) begin
            t_mem[wa32[TBW-1:0]] <= i_cmd.write_value;
        end
        r_tq <= t_mem[t_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == gbi_pkg::OP_WR_VAL) begin
            v_mem[wa32[TAW-1:0]] <= i_cmd.write_value;
        end
        r_vq  <= v_mem[v_idx[TAW-1:0]];
        r_vok <= 32'(v_idx) < TBL_DEPTH;
    end

    assign vval = r_vok ? r_vq : 32'sd0;

    // shared multiplier and half-up rounding
    always_comb begin
        mul_a = {1'b0, gbi_pkg::ONE_W - r_uk};
        mul_b = 34'(r_v00);
        case (r_state)
            gbi_pkg::S_M1: begin
                mul_a = {1'b0, r_uk};
                mul_b = 34'(r_v01);
            end
            gbi_pkg::S_M2: mul_b = 34'(r_v10);
            gbi_pkg::S_M3: begin
                mul_a = {1'b0, r_uk};
                mul_b = 34'(r_v11);
            end
            gbi_pkg::S_M4: begin
                mul_a = {1'b0, gbi_pkg::ONE_W - r_ut};
                mul_b = r_lo;
            end
            gbi_pkg::S_M5: begin
                mul_a = {1'b0, r_ut};
                mul_b = r_hi;
            end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;
    assign acc  = 53'(r_p) + 53'(prod) + 53'sd32768;
    assign rnd  = 37'(acc >>> 16);

    assign k_match = (r_qk >= r_prev && r_qk <= r_kq) || (r_i == kc - KCW'(1));

    // divider requests at the end of each search
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = {r_qk[31], r_qk} - {r_prev[31], r_prev};
        div_req.den   = {r_kq[31], r_kq} - {r_prev[31], r_prev};
        if (r_state == gbi_pkg::S_T_CK) begin
            div_req.start = r_tq >= r_qt;
            div_req.num   = {r_qt[31], r_qt} - {r_prev[31], r_prev};
            div_req.den   = {r_tq[31], r_tq} - {r_prev[31], r_prev};
        end else if (r_state == gbi_pkg::S_K_CK) begin
            div_req.start = k_match;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        unique case (r_state)
            gbi_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == gbi_pkg::OP_QUERY) begin
                        n_state = gbi_pkg::S_T_RL;
                    end
                end
            end
            gbi_pkg::S_T_RL: n_state = gbi_pkg::S_T_CL;
            gbi_pkg::S_T_CL: n_state = gbi_pkg::S_T_C0;
            gbi_pkg::S_T_C0: begin
                if (r_qt < r_tq || r_qt >= r_last) begin
                    n_state = gbi_pkg::S_K_RL;
                end else begin
                    n_state = gbi_pkg::S_T_RD;
                end
            end
            gbi_pkg::S_T_RD: n_state = gbi_pkg::S_T_CK;
            gbi_pkg::S_T_CK: n_state = div_req.start ? gbi_pkg::S_T_DIV : gbi_pkg::S_T_RD;
            gbi_pkg::S_T_DIV: if (div_rsp.done) n_state = gbi_pkg::S_K_RL;
            gbi_pkg::S_K_RL: n_state = gbi_pkg::S_K_CL;
            gbi_pkg::S_K_CL: n_state = (r_qk > r_kq) ? gbi_pkg::S_IX0 : gbi_pkg::S_K_C0;
            gbi_pkg::S_K_C0: n_state = (r_qk < r_kq) ? gbi_pkg::S_IX0 : gbi_pkg::S_K_RD;
            gbi_pkg::S_K_RD: n_state = gbi_pkg::S_K_CK;
            gbi_pkg::S_K_CK: n_state = k_match ? gbi_pkg::S_K_DIV : gbi_pkg::S_K_RD;
            gbi_pkg::S_K_DIV: if (div_rsp.done) n_state = gbi_pkg::S_IX0;
            gbi_pkg::S_IX0: n_state = gbi_pkg::S_IX1;
            gbi_pkg::S_IX1: n_state = gbi_pkg::S_IX2;
            gbi_pkg::S_IX2: n_state = gbi_pkg::S_V0;
            gbi_pkg::S_V0:  n_state = gbi_pkg::S_V1;
            gbi_pkg::S_V1:  n_state = gbi_pkg::S_V2;
            gbi_pkg::S_V2:  n_state = gbi_pkg::S_V3;
            gbi_pkg::S_V3:  n_state = gbi_pkg::S_V4;
            gbi_pkg::S_V4:  n_state = gbi_pkg::S_M0;
            gbi_pkg::S_M0:  n_state = gbi_pkg::S_M1;
            gbi_pkg::S_M1:  n_state = gbi_pkg::S_M2;
            gbi_pkg::S_M2:  n_state = gbi_pkg::S_M3;
            gbi_pkg::S_M3:  n_state = gbi_pkg::S_M4;
            gbi_pkg::S_M4:  n_state = gbi_pkg::S_M5;
            gbi_pkg::S_M5:  n_state = gbi_pkg::S_DONE;
            gbi_pkg::S_DONE: if (!r_out_valid) n_state = gbi_pkg::S_IDLE;
            default: n_state = gbi_pkg::S_IDLE;
        endcase
    end

    // datapath registers of the query
    always_ff @(posedge i_clk) begin
        case (r_state)
            gbi_pkg::S_IDLE: begin
                r_qk  <= i_cmd.query_k;
                r_qt  <= i_cmd.query_log_tau;
                r_src <= i_cmd.source;
            end
            gbi_pkg::S_T_CL: r_last <= r_tq;
            gbi_pkg::S_T_C0: begin
                r_prev <= r_tq;
                r_i    <= KCW'(1);
                r_tcl  <= 1'b0;
                if (r_qt < r_tq) begin
                    r_tb  <= '0;
                    r_ut  <= '0;
                    r_tcl <= 1'b1;
                end else if (r_qt >= r_last) begin
                    r_tb  <= TBW'(tc - TCW'(2));
                    r_ut  <= gbi_pkg::ONE_W;
                    r_tcl <= r_qt > r_last;
                end
            end
            gbi_pkg::S_T_CK: begin
                if (div_req.start) begin
                    r_tb <= TBW'(r_i - KCW'(1));
                end else begin
                    r_prev <= r_tq;
                    r_i    <= r_i + KCW'(1);
                end
            end
            gbi_pkg::S_T_DIV: if (div_rsp.done) r_ut <= div_rsp.weight;
            gbi_pkg::S_K_CL: begin
                r_kcl <= 1'b0;
                if (r_qk > r_kq) begin
                    r_kb  <= KBW'(kc - KCW'(2));
                    r_uk  <= gbi_pkg::ONE_W;
                    r_kcl <= 1'b1;
                end
            end
            gbi_pkg::S_K_C0: begin
                r_prev <= r_kq;
                r_i    <= KCW'(1);
                if (r_qk < r_kq) begin
                    r_kb  <= '0;
                    r_uk  <= '0;
                    r_kcl <= 1'b1;
                end
            end
            gbi_pkg::S_K_CK: begin
                if (k_match) begin
                    r_kb <= KBW'(r_i - KCW'(1));
                end else begin
                    r_prev <= r_kq;
                    r_i    <= r_i + KCW'(1);
                end
            end
            gbi_pkg::S_K_DIV: if (div_rsp.done) r_uk <= div_rsp.weight;
            gbi_pkg::S_IX0: r_m <= IW'(r_src) * IW'(kc);
            gbi_pkg::S_IX1: begin
                r_base <= IW'(r_m * IW'(tc));
                r_row  <= IW'(IW'(r_tb) * IW'(kc));
            end
            gbi_pkg::S_IX2: r_idx <= r_base + r_row + IW'(r_kb);
            gbi_pkg::S_V1:  r_v00 <= vval;
            gbi_pkg::S_V2:  r_v01 <= vval;
            gbi_pkg::S_V3:  r_v10 <= vval;
            gbi_pkg::S_V4:  r_v11 <= vval;
            gbi_pkg::S_M0:  r_p  <= prod;
            gbi_pkg::S_M1:  r_lo <= rnd[33:0];
            gbi_pkg::S_M2:  r_p  <= prod;
            gbi_pkg::S_M3:  r_hi <= rnd[33:0];
            gbi_pkg::S_M4:  r_p  <= prod;
            gbi_pkg::S_M5:  r_r  <= rnd;
            default: ;
        endcase
        // clear the accumulator before each pair of products
        if (r_state == gbi_pkg::S_V4 || r_state == gbi_pkg::S_M1
                || r_state == gbi_pkg::S_M3) begin
            r_p <= '0;
        end
    end

    // result register: saturate and hold until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == gbi_pkg::S_DONE && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (pop && r_out_valid) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gbi_pkg::S_DONE && !r_out_valid) begin
            r_out.k_bin       <= 8'(32'(r_kb));
            r_out.tau_bin     <= 6'(32'(r_tb));
            r_out.k_clamped   <= r_kcl;
            r_out.tau_clamped <= r_tcl;
            if (r_r > MAXV) begin
                r_out.result_value <= 32'sh7FFFFFFF;
                r_out.saturated    <= 1'b1;
            end else if (r_r < MINV) begin
                r_out.result_value <= 32'sh80000000;
                r_out.saturated    <= 1'b1;
            end else begin
                r_out.result_value <= r_r[31:0];
                r_out.saturated    <= 1'b0;
            end
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

    a_done_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbi_pkg::S_DONE && !r_out_valid) |=> r_out_valid)
        else $error("finished query did not reach the result register");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (div_rsp.weight <= gbi_pkg::ONE_W))
        else $error("weight above 1.0");

    a_tau_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbi_pkg::S_IX0) |-> (32'(r_tb) + 2 <= 32'(tc)))
        else $error("time bin beyond the grid");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == gbi_pkg::S_IDLE || r_state == gbi_pkg::S_T_RL))
        else $error("command taken outside idle");
endmodule

>>> src/grid_bilinear_interpolator_core.sv
// Grid bilinear interpolator: input queue interface, sequencer with grid/table
// memories, result queue interface. Depends on gbi_pkg, gbi_front and gbi_back.
//
// Usage: items enter on i_item with push while full is low. func selects a
// write to the k grid, the log-time grid or the value table (one beat each,
// out-of-range addresses dropped) or a query. Each query yields one result
// on o_result while empty is low; pop takes it. Configuration (k_count,
// tau_count) is written over i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data;
// ready is always high; write only while the block is idle.
// Sequencing: commands are taken only in the idle state, where a write
// completes. In a query, each grid point scanned costs a memory read and a
// compare, each weight a divider wait (settled at start when the weight is
// 0 or 1), then four table reads and six steps of the single shared
// multiplier. Items waiting ahead in the front queue delay a query's result.
// The front queue keeps taking items while a result waits; when the
// receiver stalls, the result register holds and the sequencer waits at the
// next query end, so the front queue then fills and raises full.
// Reset clears queues, the sequencer and the counts (256 and 64); memory
// contents are undefined until written.
module grid_bilinear_interpolator_core #(
    parameter int K_POINTS   = gbi_pkg::K_POINTS_DEF,
    parameter int TAU_POINTS = gbi_pkg::TAU_POINTS_DEF,
    parameter int SOURCES    = gbi_pkg::SOURCES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  gbi_pkg::t_in_item          i_item,
    output logic                       empty,
    input  logic                       pop,
    output gbi_pkg::t_out_item         o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gbi_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [gbi_pkg::CFG_DW-1:0] i_cfg_data
);
    logic          cmd_valid, cmd_pop;
    gbi_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    gbi_front #(
        .K_POINTS   (K_POINTS),
        .TAU_POINTS (TAU_POINTS),
        .SOURCES    (SOURCES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    gbi_back #(
        .K_POINTS   (K_POINTS),
        .TAU_POINTS (TAU_POINTS),
        .SOURCES    (SOURCES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );
endmodule

>>> tb/grid_bilinear_interpolator_core_tb.sv
// Self-checking testbench of grid_bilinear_interpolator_core: grid and table loads,
// queries with bin search, clamping and blend checked against an in-bench predictor.
// Depends on gbi_pkg and the core RTL.
module grid_bilinear_interpolator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  KP = gbi_pkg::K_POINTS_DEF;
    localparam int  TP = gbi_pkg::TAU_POINTS_DEF;
    localparam int  SETTLE = 900;
    localparam longint CYCLE_LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    gbi_pkg::t_in_item i_item = '0;
    logic i_cfg_valid = 1'b0;
    logic [gbi_pkg::CFG_IW-1:0] i_cfg_index = '0;
    logic [gbi_pkg::CFG_DW-1:0] i_cfg_data = '0;
    logic full, empty, o_cfg_ready;
    gbi_pkg::t_out_item o_result;

    grid_bilinear_interpolator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the block state
    logic signed [31:0] k_pts [KP];
    logic signed [31:0] tau_pts [TP];
    logic signed [31:0] val_tab [65536];
    bit                 val_set [65536];
    int unsigned        k_count_reg = 256;
    int unsigned        tau_count_reg = 64;

    gbi_pkg::t_in_item  pending_items[$];
    gbi_pkg::t_out_item expected_results[$];

    int  fail_count = 0;
    int  results_seen = 0;
    bit  calm = 1'b0;
    bit  push_taken = 1'b0;
    bit  pop_taken = 1'b0;
    int  push_gap = 0;
    int  pop_gap = 0;
    int  hold_left = 0;
    bit  hold_used = 1'b0;
    longint cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 90);
    endfunction

    function automatic int unsigned eff_count(int unsigned c, int unsigned top);
        if (c < 2) return 2;
        if (c > top) return top;
        return c;
    endfunction

    function automatic int unsigned frac_weight(longint num, longint den);
        if (den <= 0 || num <= 0) return 0;
        if (num >= den) return 65536;
        return int'((num <<< 16) / den);
    endfunction

    // floor of (x / 2^16 + 1/2)
    function automatic longint round_half_up(longint x);
        return (x + 32768) >>> 16;
    endfunction

    task automatic locate_tau(input int q, input int unsigned n, output int unsigned bin,
                              output int unsigned w, output bit cl);
        cl = 1'b0;
        if (q < tau_pts[0]) begin
            bin = 0; w = 0; cl = 1'b1;
        end else if (q >= tau_pts[n-1]) begin
            bin = n - 2; w = 65536; cl = (q > tau_pts[n-1]);
        end else begin
            bin = n - 2;
            for (int i = 1; i < n; i++) begin
                if (tau_pts[i] >= q) begin
                    bin = i - 1;
                    break;
                end
            end
            w = frac_weight(longint'(q) - tau_pts[bin],
                            longint'(tau_pts[bin+1]) - tau_pts[bin]);
        end
    endtask

    // above the grid is checked before below it
    task automatic locate_k(input int q, input int unsigned n, output int unsigned bin,
                            output int unsigned w, output bit cl);
        cl = 1'b0;
        if (q > k_pts[n-1]) begin
            bin = n - 2; w = 65536; cl = 1'b1;
        end else if (q < k_pts[0]) begin
            bin = 0; w = 0; cl = 1'b1;
        end else begin
            bin = n - 2;
            for (int i = 0; i + 1 < n; i++) begin
                if (q >= k_pts[i] && q <= k_pts[i+1]) begin
                    bin = i;
                    break;
                end
            end
            w = frac_weight(longint'(q) - k_pts[bin], longint'(k_pts[bin+1]) - k_pts[bin]);
        end
    endtask

    function automatic gbi_pkg::t_in_item noise_fields();
        gbi_pkg::t_in_item it;
        it.func = 2'($urandom);
        it.write_address = 16'($urandom);
        it.write_value = $urandom;
        it.query_k = $urandom;
        it.query_log_tau = $urandom;
        it.source = 2'($urandom);
        return it;
    endfunction

    // queue a write beat and apply it to the shadow state
    task automatic add_write(input gbi_pkg::t_op op, input int unsigned addr, input int val);
        gbi_pkg::t_in_item it;
        it = noise_fields();
        it.func = op;
        it.write_address = addr[15:0];
        it.write_value = val;
        case (op)
            gbi_pkg::OP_WR_K: begin
                if (it.write_address < KP) k_pts[it.write_address] = val;
            end
            gbi_pkg::OP_WR_TAU: begin
                if (it.write_address < TP) tau_pts[it.write_address] = val;
            end
            default: begin
                val_tab[it.write_address] = val;
                val_set[it.write_address] = 1'b1;
            end
        endcase
        pending_items.push_back(it);
    endtask

    function automatic int table_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'h7FFF_FFFF;
        if (r < 10) return 32'h8000_0000;
        if (r < 30) return $urandom_range(0, 2000000) - 1000000;
        return $urandom;
    endfunction

    // queue a query; table entries it reads are loaded first when still unset
    task automatic add_query(input int qk, input int qt, input logic [1:0] src);
        int unsigned kc, tc, kb, tb, uk, ut, base;
        int unsigned tap [4];
        bit kcl, tcl, sat;
        longint lo, hi, r;
        gbi_pkg::t_in_item it;
        gbi_pkg::t_out_item res;
        kc = eff_count(k_count_reg, KP);
        tc = eff_count(tau_count_reg, TP);
        locate_tau(qt, tc, tb, ut, tcl);
        locate_k(qk, kc, kb, uk, kcl);
        base = src * kc * tc;
        tap[0] = base + tb * kc + kb;
        tap[1] = tap[0] + 1;
        tap[2] = base + (tb + 1) * kc + kb;
        tap[3] = tap[2] + 1;
        foreach (tap[i])
            if (!val_set[tap[i]]) add_write(gbi_pkg::OP_WR_VAL, tap[i], table_word());
        lo = round_half_up(longint'(65536 - uk) * val_tab[tap[0]]
                           + longint'(uk) * val_tab[tap[1]]);
        hi = round_half_up(longint'(65536 - uk) * val_tab[tap[2]]
                           + longint'(uk) * val_tab[tap[3]]);
        r = round_half_up(longint'(65536 - ut) * lo + longint'(ut) * hi);
        sat = 1'b0;
        if (r > 64'sh7FFF_FFFF) begin
            r = 64'sh7FFF_FFFF; sat = 1'b1;
        end
        if (r < -64'sh8000_0000) begin
            r = -64'sh8000_0000; sat = 1'b1;
        end
        it = noise_fields();
        it.func = gbi_pkg::OP_QUERY;
        it.query_k = qk;
        it.query_log_tau = qt;
        it.source = src;
        pending_items.push_back(it);
        res.result_value = r[31:0];
        res.k_bin = kb[7:0];
        res.tau_bin = tb[5:0];
        res.k_clamped = kcl;
        res.tau_clamped = tcl;
        res.saturated = sat;
        expected_results.push_back(res);
    endtask

    // ascending grids with random spacing, a few repeated points
    task automatic lay_grids(input int unsigned nk, input int unsigned nt);
        longint v;
        v = -longint'($urandom_range(0, 1 << 30));
        for (int i = 0; i < nk; i++) begin
            add_write(gbi_pkg::OP_WR_K, i, int'(v));
            v += ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 1 << 23);
        end
        v = -longint'($urandom_range(0, 1 << 29));
        for (int i = 0; i < nt; i++) begin
            add_write(gbi_pkg::OP_WR_TAU, i, int'(v));
            v += ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 1 << 24);
        end
    endtask

    function automatic int pick_coord(bit on_k);
        int unsigned n, i;
        int lo, hi, r;
        n = on_k ? eff_count(k_count_reg, KP) : eff_count(tau_count_reg, TP);
        r = $urandom_range(0, 99);
        i = $urandom_range(0, n - 2);
        lo = on_k ? k_pts[i] : tau_pts[i];
        hi = on_k ? k_pts[i+1] : tau_pts[i+1];
        if (r < 60) return (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
        if (r < 72) return lo;
        if (r < 78) return on_k ? k_pts[n-1] : tau_pts[n-1];
        if (r < 90) return $urandom;
        return (r < 95) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    task automatic cfg_write(input logic [gbi_pkg::CFG_IW-1:0] idx,
                             input logic [gbi_pkg::CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == gbi_pkg::CFG_K_COUNT) k_count_reg = 32'(data[8:0]);
        else if (idx == gbi_pkg::CFG_TAU_COUNT) tau_count_reg = 32'(data[6:0]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || push || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_items(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                add_query(pick_coord(1'b1), pick_coord(1'b0), 2'($urandom));
            end else if (r < 94) begin
                add_write(gbi_pkg::OP_WR_VAL, $urandom_range(0, 65535), table_word());
            end else begin
                // out-of-range addresses mostly; in-range ones break the ordering
                add_write(gbi_pkg::t_op'($urandom_range(0, 1)), $urandom_range(0, 65535),
                          $urandom);
            end
        end
    endtask

    // stimulus plan
    initial begin
        int unsigned kn [6] = '{2, 0, 511, 5, 17, 256};
        int unsigned tn [6] = '{2, 1, 127, 3, 9, 64};
        foreach (val_set[i]) val_set[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset counts: full grids, then directed corners
        lay_grids(KP, TP);
        add_write(gbi_pkg::OP_WR_K, 256, 32'h1234_5678);
        add_write(gbi_pkg::OP_WR_TAU, 64, 32'h1234_5678);
        add_write(gbi_pkg::OP_WR_K, 16'hFFFF, 32'hFFFF_FFFF);
        add_query(32'sh8000_0000, tau_pts[0], 2'd0);
        add_query(32'sh7FFF_FFFF, tau_pts[TP-1], 2'd1);
        add_query(k_pts[0], 32'sh8000_0000, 2'd2);
        add_query(k_pts[KP-1], 32'sh7FFF_FFFF, 2'd3);
        add_query(k_pts[100] + 1, tau_pts[30] + 1, 2'd0);
        add_query(k_pts[KP-1] + 1, tau_pts[TP-1] - 1, 2'd1);
        add_query(k_pts[0] - 1, tau_pts[0] - 1, 2'd2);
        add_query(32'sh0000_0000, 32'sh0000_0000, 2'd3);
        add_query($urandom, $urandom, 2'd3);
        random_items(80);
        drain();

        foreach (kn[p]) begin
            cfg_write(gbi_pkg::CFG_K_COUNT, 16'(kn[p]));
            cfg_write(gbi_pkg::CFG_TAU_COUNT, 16'(tn[p]));
            calm = (p == 3);
            // full-size grids are still loaded from the first phase
            if (eff_count(k_count_reg, KP) < KP || eff_count(tau_count_reg, TP) < TP)
                lay_grids(eff_count(k_count_reg, KP), eff_count(tau_count_reg, TP));
            random_items((p == 2 || p == 5) ? 30 : 50);
            drain();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // record handshakes at the rising edge
    always @(posedge i_clk) begin
        push_taken <= push && !full;
        pop_taken <= pop && !empty;
    end

    // input driver: advance on an accepted beat, hold otherwise
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !push_taken) begin
            push <= 1'b1;
        end else if (push_gap != 0) begin
            push_gap <= push_gap - 1;
            push <= 1'b0;
        end else if (pending_items.size() != 0) begin
            i_item <= pending_items.pop_front();
            push <= 1'b1;
            push_gap <= pick_gap();
        end else begin
            push <= 1'b0;
        end
    end

    // one long receiver hold-off so the input side backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && results_seen == 40) begin
            hold_left <= 3000;
            hold_used <= 1'b1;
        end
    end

    // result ready side
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left != 0) begin
            pop <= 1'b0;
        end else if (pop_gap != 0) begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end else if (pop && pop_taken) begin
            pop_gap <= pick_gap();
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        gbi_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat %p", o_result);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.result_value !== want.result_value) begin
                    $error("result_value exp %0d got %0d", want.result_value,
                           o_result.result_value);
                    fail_count++;
                end
                if (o_result.k_bin !== want.k_bin) begin
                    $error("k_bin exp %0d got %0d", want.k_bin, o_result.k_bin);
                    fail_count++;
                end
                if (o_result.tau_bin !== want.tau_bin) begin
                    $error("tau_bin exp %0d got %0d", want.tau_bin, o_result.tau_bin);
                    fail_count++;
                end
                if (o_result.k_clamped !== want.k_clamped) begin
                    $error("k_clamped exp %0b got %0b", want.k_clamped, o_result.k_clamped);
                    fail_count++;
                end
                if (o_result.tau_clamped !== want.tau_clamped) begin
                    $error("tau_clamped exp %0b got %0b", want.tau_clamped,
                           o_result.tau_clamped);
                    fail_count++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $error("saturated exp %0b got %0b", want.saturated, o_result.saturated);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
